// ===== rtl/selective_repeat_receiver_top_defines.svh =====
// Assertion macros for a file that checks its own logic.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SELECTIVE_REPEAT_RECEIVER_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srr_pkg.sv =====
`timescale 1ns / 1ps

package srr_pkg;

    // Result kinds.
    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    // The payload sum takes two bytes in each step of the shared adder.
    localparam int PAYLOAD_BYTES = 20;
    localparam int SUM_STEPS     = PAYLOAD_BYTES / 2;

    typedef struct packed {
        logic [30:0]        seq_num;
        logic [30:0]        ack_num;
        logic signed [31:0] checksum_in;
        logic [63:0]        payload_low;
        logic [63:0]        payload_mid;
        logic [31:0]        payload_high;
    } pkt_word_t;

    typedef struct packed {
        logic               result_kind;
        logic [30:0]        result_seq;
        logic signed [31:0] ack_checksum;
        logic [63:0]        out_payload_low;
        logic [63:0]        out_payload_mid;
        logic [31:0]        out_payload_high;
        logic               last_of_run;
    } res_word_t;

    // One buffered packet as held in the slot memory.
    typedef struct packed {
        logic [30:0] seq;
        logic [31:0] payload_high;
        logic [63:0] payload_mid;
        logic [63:0] payload_low;
    } slot_t;

endpackage

// ===== rtl/srr_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/selective_repeat_receiver_top.sv =====
// Selective-repeat receiver. Each word on the pkt channel is one packet; its checksum
// (sequence number plus ack number plus the twenty payload bytes taken as signed values,
// mod 2^32) is summed by one shared adder at two bytes a cycle, and every packet finishes
// the checksum before anything else happens. A bad packet is dropped with no result. A
// packet at the receive base is delivered, followed by each buffered successor until the
// first empty slot (at most WINDOW_SIZE-1 of them), and the base moves past them; a packet
// ahead of the base inside the window is stored once in the slot memory; a packet from the
// previous window is only acknowledged; any other packet is dropped. Every packet that is
// not dropped ends with one ack word, flagged by last_of_run. Each released successor
// passes through ST_WALK_CHK, which tests its slot, and ST_WALK_OUT, which reads it
// from the registered-output slot memory. The block holds pkt_stall high from acceptance
// until the packet is dropped or its last result has been loaded into the res output
// register, which then waits for the sink independently.

`timescale 1ns / 1ps
`include "selective_repeat_receiver_top_defines.svh"

module selective_repeat_receiver_top #(
    parameter int WINDOW_SIZE = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pkt_valid,
    output logic              pkt_stall,
    input  srr_pkg::pkt_word_t pkt,
    output logic              res_valid,
    input  logic              res_stall,
    output srr_pkg::res_word_t res
);

    localparam int IDXW = $clog2(WINDOW_SIZE);
    localparam int SLOT_W = $bits(srr_pkg::slot_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_DELIVER,
        ST_WALK_CHK,
        ST_WALK_OUT,
        ST_BUF_IDX,
        ST_BUF_RD,
        ST_BUF_CMP,
        ST_ACK
    } state_t;

    state_t             state_reg, state_next;
    srr_pkg::pkt_word_t pkt_reg, pkt_next;
    logic [31:0]        acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [30:0]        base_reg, base_next;
    // basemod_reg always equals the receive base modulo WINDOW_SIZE.
    logic [IDXW-1:0]    basemod_reg, basemod_next;
    logic [IDXW-1:0]    ptr_reg, ptr_next;
    logic [IDXW-1:0]    walked_reg, walked_next;
    logic [WINDOW_SIZE-1:0] slot_full_reg, slot_full_next;
    logic               res_valid_reg, res_valid_next;
    srr_pkg::res_word_t res_reg, res_next;

    // Slot memory port signals.
    logic               ram_we;
    srr_pkg::slot_t     ram_wdata;
    srr_pkg::slot_t     ram_rdata;
    logic [SLOT_W-1:0]  ram_rbits;

    // Datapath helpers.
    logic [159:0]       pay_bits;
    logic [15:0]        pair;
    logic signed [8:0]  pair_sum;
    logic [31:0]        sum_total;
    logic               is_base;
    logic               is_ahead;
    logic               is_prev;
    logic [30:0]        seq_diff;
    logic [IDXW:0]      idx_wide;
    logic [IDXW-1:0]    buf_idx;
    logic [30:0]        base_inc;
    logic [IDXW-1:0]    basemod_inc;
    logic [IDXW-1:0]    ptr_inc;
    logic               res_free;

    // Conditions used by the checks at the end of the module.
    logic               pkt_accept;
    logic               sum_started;
    logic               ack_loading;
    logic               ack_in_reg;
    logic               walk_loading;
    logic               delivery_in_reg;
    logic               delivery_clean;

    assign pkt_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_free  = !res_valid_reg || !res_stall;

    // The shared adder takes the next two payload bytes, each sign extended.
    assign pay_bits = {pkt_reg.payload_high, pkt_reg.payload_mid, pkt_reg.payload_low};
    assign pair     = pay_bits[{cnt_reg, 4'b0000} +: 16];
    assign pair_sum = $signed({pair[7], pair[7:0]}) + $signed({pair[15], pair[15:8]});

    assign sum_total = {1'b0, pkt_reg.seq_num} + {1'b0, pkt_reg.ack_num} + acc_reg;

    // Window tests work on the unwrapped values, so the previous window may
    // reach below zero while the base is small.
    assign is_base  = (pkt_reg.seq_num == base_reg);
    assign is_ahead = (pkt_reg.seq_num > base_reg)
                   && ({1'b0, pkt_reg.seq_num} < ({1'b0, base_reg} + 32'(WINDOW_SIZE)));
    assign is_prev  = (pkt_reg.seq_num < base_reg)
                   && (({1'b0, pkt_reg.seq_num} + 32'(WINDOW_SIZE)) >= {1'b0, base_reg});

    // Slot of a packet ahead of the base: (base + d - 1) mod W with 0 < d < W,
    // which needs only one conditional subtract.
    assign seq_diff = pkt_reg.seq_num - base_reg;
    assign idx_wide = {1'b0, basemod_reg} + seq_diff[IDXW:0] - (IDXW+1)'(1);
    assign buf_idx  = (idx_wide >= (IDXW+1)'(WINDOW_SIZE))
                    ? IDXW'(idx_wide - (IDXW+1)'(WINDOW_SIZE)) : idx_wide[IDXW-1:0];

    // The base advances mod 2^31; its residue follows, and restarts at zero on wrap.
    assign base_inc    = base_reg + 31'd1;
    assign basemod_inc = (base_inc == 31'd0) ? '0
                       : ((basemod_reg == IDXW'(WINDOW_SIZE - 1)) ? '0 : basemod_reg + 1'b1);
    assign ptr_inc     = (ptr_reg == IDXW'(WINDOW_SIZE - 1)) ? '0 : ptr_reg + 1'b1;

    assign ram_wdata = '{seq:          pkt_reg.seq_num,
                         payload_high: pkt_reg.payload_high,
                         payload_mid:  pkt_reg.payload_mid,
                         payload_low:  pkt_reg.payload_low};
    assign ram_rdata = srr_pkg::slot_t'(ram_rbits);

    srr_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(WINDOW_SIZE)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rbits)
    );

    always_comb
    begin
        state_next     = state_reg;
        pkt_next       = pkt_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        basemod_next   = basemod_reg;
        ptr_next       = ptr_reg;
        walked_next    = walked_reg;
        slot_full_next = slot_full_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pkt_valid)
                begin
                    pkt_next   = pkt;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                acc_next = acc_reg + {{23{pair_sum[8]}}, pair_sum};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(srr_pkg::SUM_STEPS - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sum_total != pkt_reg.checksum_in)
                begin
                    state_next = ST_IDLE;
                end
                else if (is_base)
                begin
                    state_next = ST_DELIVER;
                end
                else if (is_ahead)
                begin
                    state_next = ST_BUF_IDX;
                end
                else if (is_prev)
                begin
                    state_next = ST_ACK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DELIVER:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{result_kind:      srr_pkg::KIND_DELIVER,
                                 result_seq:       pkt_reg.seq_num,
                                 ack_checksum:     '0,
                                 out_payload_low:  pkt_reg.payload_low,
                                 out_payload_mid:  pkt_reg.payload_mid,
                                 out_payload_high: pkt_reg.payload_high,
                                 last_of_run:      1'b0};
                    // The first successor sits in slot base mod W.
                    ptr_next     = basemod_reg;
                    walked_next  = '0;
                    base_next    = base_inc;
                    basemod_next = basemod_inc;
                    state_next   = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK:
            begin
                if ((walked_reg == IDXW'(WINDOW_SIZE - 1)) || !slot_full_reg[ptr_reg])
                begin
                    state_next = ST_ACK;
                end
                else
                begin
                    state_next = ST_WALK_OUT;
                end
            end
            ST_WALK_OUT:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{result_kind:      srr_pkg::KIND_DELIVER,
                                 result_seq:       ram_rdata.seq,
                                 ack_checksum:     '0,
                                 out_payload_low:  ram_rdata.payload_low,
                                 out_payload_mid:  ram_rdata.payload_mid,
                                 out_payload_high: ram_rdata.payload_high,
                                 last_of_run:      1'b0};
                    slot_full_next[ptr_reg] = 1'b0;
                    ptr_next     = ptr_inc;
                    walked_next  = walked_reg + 1'b1;
                    base_next    = base_inc;
                    basemod_next = basemod_inc;
                    state_next   = ST_WALK_CHK;
                end
            end
            ST_BUF_IDX:
            begin
                ptr_next   = buf_idx;
                state_next = ST_BUF_RD;
            end
            ST_BUF_RD:
            begin
                state_next = ST_BUF_CMP;
            end
            ST_BUF_CMP:
            begin
                // A slot that already holds this packet keeps its first copy.
                if (!(slot_full_reg[ptr_reg] && (ram_rdata.seq == pkt_reg.seq_num)))
                begin
                    ram_we = 1'b1;
                    slot_full_next[ptr_reg] = 1'b1;
                end
                state_next = ST_ACK;
            end
            ST_ACK:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = '{result_kind:      srr_pkg::KIND_ACK,
                                 result_seq:       pkt_reg.seq_num,
                                 ack_checksum:     {pkt_reg.seq_num, 1'b0} + acc_reg,
                                 out_payload_low:  pkt_reg.payload_low,
                                 out_payload_mid:  pkt_reg.payload_mid,
                                 out_payload_high: pkt_reg.payload_high,
                                 last_of_run:      1'b1};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            base_reg      <= 31'd1;
            basemod_reg   <= IDXW'(1);
            ptr_reg       <= '0;
            walked_reg    <= '0;
            slot_full_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pkt_reg       <= pkt_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            base_reg      <= base_next;
            basemod_reg   <= basemod_next;
            ptr_reg       <= ptr_next;
            walked_reg    <= walked_next;
            slot_full_reg <= slot_full_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign pkt_accept      = pkt_valid && !pkt_stall;
    assign sum_started     = (state_reg == ST_SUM) && (cnt_reg == 4'd0);
    assign ack_loading     = (state_reg == ST_ACK) && res_free;
    assign ack_in_reg      = (state_reg == ST_IDLE) && res_valid && res.last_of_run
                          && (res.result_kind == srr_pkg::KIND_ACK);
    assign walk_loading    = (state_reg == ST_WALK_OUT) && res_free;
    assign delivery_in_reg = res_valid && (res.result_kind == srr_pkg::KIND_DELIVER);
    assign delivery_clean  = !res.last_of_run && (res.ack_checksum == 32'sd0);

    // An accepted packet always starts the checksum from its first byte pair.
    `SRR_ASSERT_NEXT(a_accept_starts_sum, pkt_accept, sum_started, "checksum did not start")

    // Loading the ack ends the packet and leaves a last-of-run ack in the output register.
    `SRR_ASSERT_NEXT(a_ack_ends_run, ack_loading, ack_in_reg, "ack did not close the run")

    // A buffered packet that has been delivered leaves its slot empty.
    `SRR_ASSERT_NEXT(a_walk_frees_slot, walk_loading, !slot_full_reg[$past(ptr_reg)], "slot kept")

    // A delivery is never marked as the last result of a packet.
    `SRR_ASSERT_SAME(a_delivery_not_last, delivery_in_reg, delivery_clean, "bad delivery word")

endmodule
